FILE: rtl/ata_taskfile_address_writer_macros.svh
// ---------------------------------------------------------------------------
// ata_taskfile_address_writer_macros.svh
// Assertion macros shared by the checker of the task-file address writer.
// ---------------------------------------------------------------------------
`ifndef ATA_TASKFILE_ADDRESS_WRITER_MACROS_SVH
`define ATA_TASKFILE_ADDRESS_WRITER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define ATAW_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define ATAW_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ataw_pkg.sv
// ---------------------------------------------------------------------------
// ataw_pkg
// Types and constants of the ATA task-file address writer.
// ---------------------------------------------------------------------------
package ataw_pkg;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LBA_MODE    = 2'd0,
    CFG_SPT         = 2'd1,
    CFG_HEAD_COUNT  = 2'd2,
    CFG_DRIVE_SLAVE = 2'd3
  } cfg_idx_t;

  localparam logic [7:0] SPT_RESET      = 8'd63;
  localparam logic [7:0] HEADS_RESET    = 8'd16;
  localparam logic [7:0] LBA_ENABLE_BIT = 8'h40;
  localparam logic [7:0] LBA_HIGH_MASK  = 8'h0F;
  localparam logic [7:0] SELECT_MASTER  = 8'hA0;
  localparam logic [7:0] SELECT_SLAVE   = 8'hB0;

  typedef enum logic [2:0] {
    OFF_COUNT      = 3'd2,
    OFF_SECTOR     = 3'd3,
    OFF_CYL_LOW    = 3'd4,
    OFF_CYL_HIGH   = 3'd5,
    OFF_DRIVE_HEAD = 3'd6,
    OFF_COMMAND    = 3'd7
  } reg_off_t;

  localparam int QUEUE_DEPTH = 2;

  // divider: 32-bit dividend, 8-bit divisor, one quotient byte per cycle
  localparam int DIV_CYCLES = 4;
  localparam int DIV_STEP_W = 2;
  localparam logic [DIV_STEP_W-1:0] DIV_LAST_STEP = DIV_STEP_W'(DIV_CYCLES - 1);

  localparam logic [2:0] WR_FIRST_IDX = 3'd0;
  localparam logic [2:0] WR_LAST_IDX  = 3'd5;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_DIV_SECT,
    FE_DIV_HEAD,
    FE_PUSH
  } fe_state_t;

  typedef struct packed {
    logic [7:0]  command;
    logic [7:0]  count;
    logic [7:0]  sector;
    logic [15:0] cylinder;
    logic [7:0]  drive_head;
  } tf_entry_t;

  typedef struct packed {
    logic        start;
    logic [31:0] dividend;
    logic [7:0]  divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quotient;
    logic [7:0]  remainder;
  } div_rsp_t;

endpackage

FILE: rtl/ataw_intf.sv
// ---------------------------------------------------------------------------
// ataw_intf
// Request and register-write channels of the task-file address writer.
// ---------------------------------------------------------------------------
interface ataw_req_if;
  logic        valid;
  logic        ready;
  logic [7:0]  ata_command;
  logic [31:0] block_number;
  logic [7:0]  sector_count;

  modport source (output valid, ata_command, block_number, sector_count, input ready);
  modport sink   (input valid, ata_command, block_number, sector_count, output ready);
endinterface

interface ataw_wr_if;
  logic       valid;
  logic       ready;
  logic [2:0] reg_offset;
  logic [7:0] reg_value;
  logic       last_write;

  modport source (output valid, reg_offset, reg_value, last_write, input ready);
  modport sink   (input valid, reg_offset, reg_value, last_write, output ready);
endinterface

FILE: rtl/ataw_divider.sv
// ---------------------------------------------------------------------------
// ataw_divider
// Iterative 32-by-8 unsigned divider, eight quotient bits per cycle.
// ---------------------------------------------------------------------------
module ataw_divider (
  input  logic               clk,
  input  logic               rst_n,
  input  ataw_pkg::div_req_t req,
  output ataw_pkg::div_rsp_t rsp
);

  logic                            busy_r;
  logic [ataw_pkg::DIV_STEP_W-1:0] step_r;
  logic [31:0]                     quo_r;
  logic [7:0]                      rem_r;
  logic [7:0]                      dvs_r;

  logic [8:0]  acc;
  logic [7:0]  rem_nxt;
  logic [7:0]  qbyte;
  logic [31:0] quo_nxt;
  logic        done;

  always_comb begin
    rem_nxt = rem_r;
    qbyte   = '0;
    acc     = '0;
    for (int i = 0; i < 8; i++) begin
      acc = {rem_nxt, quo_r[31-i]};
      if (acc >= {1'b0, dvs_r}) begin
        acc        = acc - {1'b0, dvs_r};
        qbyte[7-i] = 1'b1;
      end
      rem_nxt = acc[7:0];
    end
    quo_nxt = {quo_r[23:0], qbyte};
  end

  assign done = busy_r && (step_r == ataw_pkg::DIV_LAST_STEP);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else if (req.start) begin
      busy_r <= 1'b1;
      step_r <= '0;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (done) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      quo_r <= req.dividend;
      rem_r <= '0;
      dvs_r <= req.divisor;
    end else if (busy_r) begin
      quo_r <= quo_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo_nxt;
  assign rsp.remainder = rem_nxt;

endmodule

FILE: rtl/ataw_front.sv
// ---------------------------------------------------------------------------
// ataw_front
// Accepts requests, holds the drive geometry and forms the task-file bytes.
// ---------------------------------------------------------------------------
module ataw_front (
  input  logic                                clk,
  input  logic                                rst_n,
  ataw_req_if.sink                            in_ch,
  input  logic                                cfg_we,
  input  logic [ataw_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ataw_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  output logic                                push_valid,
  input  logic                                push_ready,
  output ataw_pkg::tf_entry_t                 push_data
);

  logic       lba_mode_r;
  logic [7:0] spt_r;
  logic [7:0] heads_r;
  logic       slave_r;

  ataw_pkg::fe_state_t state_r, state_nxt;

  logic [7:0]  cmd_r;
  logic [7:0]  cnt_r;
  logic [7:0]  sect_r;
  logic [15:0] cyl_r;
  logic [7:0]  dh_r;

  logic [7:0] spt_eff;
  logic [7:0] heads_eff;
  logic [7:0] sel_byte;
  logic       ready;
  logic       accept;

  ataw_pkg::div_req_t div_req;
  ataw_pkg::div_rsp_t div_rsp;

  ataw_divider u_divider (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lba_mode_r <= 1'b0;
      spt_r      <= ataw_pkg::SPT_RESET;
      heads_r    <= ataw_pkg::HEADS_RESET;
      slave_r    <= 1'b0;
    end else if (cfg_we) begin
      case (ataw_pkg::cfg_idx_t'(cfg_index))
        ataw_pkg::CFG_LBA_MODE:    lba_mode_r <= cfg_wdata[0];
        ataw_pkg::CFG_SPT:         spt_r      <= cfg_wdata[7:0];
        ataw_pkg::CFG_HEAD_COUNT:  heads_r    <= cfg_wdata[7:0];
        ataw_pkg::CFG_DRIVE_SLAVE: slave_r    <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  assign spt_eff   = (spt_r == '0) ? 8'd1 : spt_r;
  assign heads_eff = (heads_r == '0) ? 8'd1 : heads_r;
  assign sel_byte  = slave_r ? ataw_pkg::SELECT_SLAVE : ataw_pkg::SELECT_MASTER;
  assign accept    = in_ch.valid && ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ataw_pkg::FE_IDLE: begin
        if (accept) begin
          state_nxt = lba_mode_r ? ataw_pkg::FE_PUSH : ataw_pkg::FE_DIV_SECT;
        end
      end
      ataw_pkg::FE_DIV_SECT: begin
        if (div_rsp.done) begin
          state_nxt = ataw_pkg::FE_DIV_HEAD;
        end
      end
      ataw_pkg::FE_DIV_HEAD: begin
        if (div_rsp.done) begin
          state_nxt = ataw_pkg::FE_PUSH;
        end
      end
      ataw_pkg::FE_PUSH: begin
        if (accept) begin
          state_nxt = lba_mode_r ? ataw_pkg::FE_PUSH : ataw_pkg::FE_DIV_SECT;
        end else if (push_ready) begin
          state_nxt = ataw_pkg::FE_IDLE;
        end
      end
      default: state_nxt = ataw_pkg::FE_IDLE;
    endcase
  end

  always_comb begin
    ready            = (state_r == ataw_pkg::FE_IDLE) ||
                       ((state_r == ataw_pkg::FE_PUSH) && push_ready);
    push_valid       = (state_r == ataw_pkg::FE_PUSH);
    div_req.start    = (accept && !lba_mode_r) ||
                       ((state_r == ataw_pkg::FE_DIV_SECT) && div_rsp.done);
    div_req.dividend = (state_r == ataw_pkg::FE_DIV_SECT) ? div_rsp.quotient
                                                          : in_ch.block_number;
    div_req.divisor  = (state_r == ataw_pkg::FE_DIV_SECT) ? heads_eff : spt_eff;
  end

  assign in_ch.ready = ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ataw_pkg::FE_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= in_ch.ata_command;
      cnt_r <= in_ch.sector_count;
      if (lba_mode_r) begin
        sect_r <= in_ch.block_number[7:0];
        cyl_r  <= in_ch.block_number[23:8];
        dh_r   <= ({4'b0000, in_ch.block_number[27:24]} & ataw_pkg::LBA_HIGH_MASK) |
                  ataw_pkg::LBA_ENABLE_BIT | sel_byte;
      end
    end else if ((state_r == ataw_pkg::FE_DIV_SECT) && div_rsp.done) begin
      sect_r <= div_rsp.remainder + 8'd1;
    end else if ((state_r == ataw_pkg::FE_DIV_HEAD) && div_rsp.done) begin
      cyl_r <= div_rsp.quotient[15:0];
      dh_r  <= div_rsp.remainder | sel_byte;
    end
  end

  assign push_data.command    = cmd_r;
  assign push_data.count      = cnt_r;
  assign push_data.sector     = sect_r;
  assign push_data.cylinder   = cyl_r;
  assign push_data.drive_head = dh_r;

endmodule

FILE: rtl/ataw_fifo.sv
// ---------------------------------------------------------------------------
// ataw_fifo
// Short queue of prepared task-file entries between front and back.
// ---------------------------------------------------------------------------
module ataw_fifo #(
  parameter int DEPTH = ataw_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push_valid,
  output logic                push_ready,
  input  ataw_pkg::tf_entry_t push_data,
  output logic                pop_valid,
  input  logic                pop,
  output ataw_pkg::tf_entry_t pop_data
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  ataw_pkg::tf_entry_t mem_r [DEPTH];
  logic [PTR_W-1:0]    wr_ptr_r;
  logic [PTR_W-1:0]    rd_ptr_r;
  logic [CNT_W-1:0]    count_r;

  logic do_push;
  logic do_pop;

  assign push_ready = (count_r != CNT_W'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_data   = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

FILE: rtl/ataw_back.sv
// ---------------------------------------------------------------------------
// ataw_back
// Emits an entry's six task-file writes, one per cycle unless stalled.
// ---------------------------------------------------------------------------
module ataw_back (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                pop_valid,
  output logic                pop,
  input  ataw_pkg::tf_entry_t pop_data,
  ataw_wr_if.source           out_ch
);

  ataw_pkg::tf_entry_t ent_r;
  logic                active_r;
  logic [2:0]          idx_r;
  logic                out_valid_r;
  logic [2:0]          out_offset_r;
  logic [7:0]          out_value_r;
  logic                out_last_r;

  logic       can_load;
  logic       emit;
  logic       emit_last;
  logic [2:0] offset_nxt;
  logic [7:0] value_nxt;

  assign can_load  = !out_valid_r || out_ch.ready;
  assign emit      = active_r && can_load;
  assign emit_last = emit && (idx_r == ataw_pkg::WR_LAST_IDX);
  assign pop       = pop_valid && (!active_r || emit_last);

  always_comb begin
    case (idx_r)
      3'd0: begin
        offset_nxt = ataw_pkg::OFF_COUNT;
        value_nxt  = ent_r.count;
      end
      3'd1: begin
        offset_nxt = ataw_pkg::OFF_SECTOR;
        value_nxt  = ent_r.sector;
      end
      3'd2: begin
        offset_nxt = ataw_pkg::OFF_CYL_LOW;
        value_nxt  = ent_r.cylinder[7:0];
      end
      3'd3: begin
        offset_nxt = ataw_pkg::OFF_CYL_HIGH;
        value_nxt  = ent_r.cylinder[15:8];
      end
      3'd4: begin
        offset_nxt = ataw_pkg::OFF_DRIVE_HEAD;
        value_nxt  = ent_r.drive_head;
      end
      default: begin
        offset_nxt = ataw_pkg::OFF_COMMAND;
        value_nxt  = ent_r.command;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      idx_r       <= ataw_pkg::WR_FIRST_IDX;
      out_valid_r <= 1'b0;
    end else begin
      if (can_load) begin
        out_valid_r <= emit;
      end
      if (pop) begin
        active_r <= 1'b1;
        idx_r    <= ataw_pkg::WR_FIRST_IDX;
      end else if (emit_last) begin
        active_r <= 1'b0;
      end else if (emit) begin
        idx_r <= idx_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= pop_data;
    end
    if (emit) begin
      out_offset_r <= offset_nxt;
      out_value_r  <= value_nxt;
      out_last_r   <= (idx_r == ataw_pkg::WR_LAST_IDX);
    end
  end

  assign out_ch.valid      = out_valid_r;
  assign out_ch.reg_offset = out_offset_r;
  assign out_ch.reg_value  = out_value_r;
  assign out_ch.last_write = out_last_r;

endmodule

FILE: rtl/ata_taskfile_address_writer.sv
// ---------------------------------------------------------------------------
// ata_taskfile_address_writer
// Turns a block request into the six ATA task-file register writes.
// ---------------------------------------------------------------------------
// Each request yields writes to count, sector, cylinder low, cylinder high,
// drive/head and command, in that order, the command write flagged as last.
// The back end emits one write per cycle while the output is not stalled.
// In LBA mode the front end forms an item straight from the request. In CHS
// mode the front end makes two passes through one shared divider that
// produces eight quotient bits a cycle, and then hands the entry to the
// queue. A queue of QUEUE_DEPTH entries lets the front accept new requests
// while writes of earlier ones are still waiting on the output.
module ata_taskfile_address_writer #(
  parameter int QUEUE_DEPTH = ataw_pkg::QUEUE_DEPTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  ataw_req_if.sink                        in_ch,
  ataw_wr_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [ataw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ataw_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  logic                push_valid;
  logic                push_ready;
  ataw_pkg::tf_entry_t push_data;
  logic                pop_valid;
  logic                pop;
  ataw_pkg::tf_entry_t pop_data;

  ataw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ataw_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  ataw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_ch    (out_ch)
  );

endmodule

FILE: rtl/ataw_checker.sv
// ---------------------------------------------------------------------------
// ataw_checker
// Port-level checks on the register-write stream of the address writer.
// ---------------------------------------------------------------------------
`include "ata_taskfile_address_writer_macros.svh"

module ataw_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] out_reg_offset,
  input logic [7:0] out_reg_value,
  input logic       out_last_write
);

  `ATAW_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_reg_offset) && $stable(out_reg_value) && $stable(out_last_write), "stalled item changed")
  `ATAW_ASSERT_IMP(a_last_on_cmd, out_valid, out_last_write == (out_reg_offset == ataw_pkg::OFF_COMMAND), "last flag off the command write")
  `ATAW_ASSERT_NXT(a_write_order, out_valid && out_ready && !out_last_write, out_valid && (out_reg_offset == 3'($past(out_reg_offset) + 3'd1)), "write sequence broken")
  `ATAW_ASSERT_IMP(a_drive_sel, out_valid && (out_reg_offset == ataw_pkg::OFF_DRIVE_HEAD), out_reg_value[7] && out_reg_value[5], "drive/head select bits missing")

endmodule

bind ata_taskfile_address_writer ataw_checker u_ataw_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_reg_offset (out_ch.reg_offset),
  .out_reg_value  (out_ch.reg_value),
  .out_last_write (out_ch.last_write)
);
